/* rtl/core/crtc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtc_pkg
// Shared constants, types and register tables of the CMOS RTC reader.
// ----------------------------------------------------------------------------
package crtc_pkg;

	// CMOS register indexes.
	localparam logic [6:0] REG_SECOND   = 7'h00;
	localparam logic [6:0] REG_MINUTE   = 7'h02;
	localparam logic [6:0] REG_HOUR     = 7'h04;
	localparam logic [6:0] REG_DAY      = 7'h07;
	localparam logic [6:0] REG_MONTH    = 7'h08;
	localparam logic [6:0] REG_YEAR     = 7'h09;
	localparam logic [6:0] REG_STATUS_A = 7'h0A;
	localparam logic [6:0] REG_STATUS_B = 7'h0B;

	// Status bits.
	localparam int UIP_BIT      = 7;
	localparam int BIN_MODE_BIT = 2;
	localparam int H24_MODE_BIT = 1;
	localparam int PM_BIT       = 7;

	// Snapshot slots.
	localparam int          NUM_SLOTS    = 7;
	localparam logic [2:0]  SLOT_SECOND  = 3'd0;
	localparam logic [2:0]  SLOT_MINUTE  = 3'd1;
	localparam logic [2:0]  SLOT_HOUR    = 3'd2;
	localparam logic [2:0]  SLOT_DAY     = 3'd3;
	localparam logic [2:0]  SLOT_MONTH   = 3'd4;
	localparam logic [2:0]  SLOT_YEAR    = 3'd5;
	localparam logic [2:0]  SLOT_CENTURY = 3'd6;

	// Configuration register indexes and reset values.
	localparam int          CFG_DATA_W        = 14;
	localparam logic        CFG_CENTURY_INDEX = 1'b0;
	localparam logic        CFG_BASE_YEAR     = 1'b1;
	localparam logic [13:0] BASE_YEAR_RESET   = 14'd2016;
	localparam logic [7:0]  BASE_CENT_RESET   = 8'd20;

	// Result kinds.
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_TIME    = 1'b1;

	// Input kinds.
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_DATA  = 1'b1;

	typedef struct packed {
		logic       wr_en;
		logic [2:0] wr_slot;
		logic       copy_prev;
		logic       convert;
		logic       emit_req;
		logic [6:0] req_index;
		logic       emit_time;
	} crtc_cmd_t;

	typedef struct packed {
		logic       cen_en;
		logic [6:0] cen_index;
		logic       snap_equal;
	} crtc_status_t;

	// CMOS register read for each time slot except the century.
	function automatic logic [6:0] slot_reg(input logic [2:0] slot);
		logic [6:0] r;
		case (slot)
			SLOT_SECOND: r = REG_SECOND;
			SLOT_MINUTE: r = REG_MINUTE;
			SLOT_HOUR:   r = REG_HOUR;
			SLOT_DAY:    r = REG_DAY;
			SLOT_MONTH:  r = REG_MONTH;
			SLOT_YEAR:   r = REG_YEAR;
			default:     r = REG_SECOND;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/crtc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtc_ctrl
// Read sequencer: walks status A, the time slots and status B, and decides
// when two consecutive snapshots agree.
// ----------------------------------------------------------------------------
module crtc_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  req_type,
	input  wire logic [7:0]            data_byte,
	input  wire crtc_pkg::crtc_status_t status,
	output logic                       busy,
	output crtc_pkg::crtc_cmd_t        cmd
);
	import crtc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT_A,
		ST_SLOT,
		ST_WAIT_B,
		ST_FINISH
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] slot_q, slot_d;
	logic       have_prev_q, have_prev_d;
	logic       accept;

	assign busy   = (state_q == ST_FINISH);
	assign accept = start && !busy;

	always_comb begin
		state_d     = state_q;
		slot_d      = slot_q;
		have_prev_d = have_prev_q;
		cmd         = '0;
		if (state_q == ST_FINISH) begin
			cmd.emit_time = 1'b1;
			state_d       = ST_IDLE;
		end else if (accept) begin
			if (req_type == REQ_START) begin
				have_prev_d   = 1'b0;
				state_d       = ST_WAIT_A;
				cmd.emit_req  = 1'b1;
				cmd.req_index = REG_STATUS_A;
			end else begin
				case (state_q)
					ST_WAIT_A: begin
						cmd.emit_req = 1'b1;
						if (data_byte[UIP_BIT]) begin
							cmd.req_index = REG_STATUS_A;
						end else begin
							state_d       = ST_SLOT;
							slot_d        = SLOT_SECOND;
							cmd.req_index = REG_SECOND;
						end
					end
					ST_SLOT: begin
						cmd.wr_en    = 1'b1;
						cmd.wr_slot  = slot_q;
						cmd.emit_req = 1'b1;
						if (slot_q < SLOT_YEAR) begin
							slot_d        = slot_q + 3'd1;
							cmd.req_index = slot_reg(slot_q + 3'd1);
						end else if (slot_q == SLOT_YEAR && status.cen_en) begin
							slot_d        = SLOT_CENTURY;
							cmd.req_index = status.cen_index;
						end else if (have_prev_q && status.snap_equal) begin
							state_d       = ST_WAIT_B;
							cmd.req_index = REG_STATUS_B;
						end else begin
							cmd.copy_prev = 1'b1;
							have_prev_d   = 1'b1;
							state_d       = ST_WAIT_A;
							cmd.req_index = REG_STATUS_A;
						end
					end
					ST_WAIT_B: begin
						cmd.convert = 1'b1;
						have_prev_d = 1'b0;
						state_d     = ST_FINISH;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= SLOT_SECOND;
			have_prev_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			slot_q      <= slot_d;
			have_prev_q <= have_prev_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/crtc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crtc_datapath
// Configuration, snapshot registers, comparison, BCD and 12-hour conversion,
// year formation and the result registers.
// ----------------------------------------------------------------------------
module crtc_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [13:0]           cfg_data,
	input  wire logic [7:0]            data_byte,
	input  wire crtc_pkg::crtc_cmd_t   cmd,
	output crtc_pkg::crtc_status_t     status,
	output logic                       done,
	output logic                       result_kind,
	output logic [6:0]                 reg_index,
	output logic [7:0]                 out_second,
	output logic [7:0]                 out_minute,
	output logic [7:0]                 out_hour,
	output logic [7:0]                 out_day,
	output logic [7:0]                 out_month,
	output logic [14:0]                out_year
);
	import crtc_pkg::*;

	function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
		return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
	endfunction

	function automatic logic [7:0] mod24(input logic [7:0] v);
		logic [7:0] r;
		r = v;
		for (int i = 0; i < 5; i++) begin
			if (r >= 8'd24) r = r - 8'd24;
		end
		return r;
	endfunction

	logic [6:0]  century_index_q;
	logic [13:0] base_year_q;
	logic [7:0]  base_cent_q;
	logic [26:0] cent_prod;

	logic [7:0] cur_q  [NUM_SLOTS];
	logic [7:0] prev_q [NUM_SLOTS];
	logic [7:0] cur_d  [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] slot_eq;
	logic [2:0] last_slot;

	logic [7:0] sec_q, min_q, hr_q, day_q, mon_q, yr_q, cen_q;
	logic       bin_mode;
	logic [7:0] hr_c, hr_24;
	logic [14:0] cen_year, floor_year, sum_year, year_d;

	logic        done_q, kind_q;
	logic [6:0]  reg_index_q;
	logic [7:0]  sec_o_q, min_o_q, hr_o_q, day_o_q, mon_o_q;
	logic [14:0] year_o_q;

	// Floor of base_year / 100 by reciprocal; exact for every 14-bit value.
	assign cent_prod = 27'(cfg_data) * 27'd5243;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			century_index_q <= '0;
			base_year_q     <= BASE_YEAR_RESET;
			base_cent_q     <= BASE_CENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTURY_INDEX: century_index_q <= cfg_data[6:0];
				CFG_BASE_YEAR: begin
					base_year_q <= cfg_data;
					base_cent_q <= cent_prod[26:19];
				end
				default: ;
			endcase
		end
	end

	// The compare is only used on the last slot of a pass, so it sees that
	// slot's byte as it arrives.
	assign last_slot = (century_index_q != 7'd0) ? SLOT_CENTURY : SLOT_YEAR;

	always_comb begin
		for (int j = 0; j < NUM_SLOTS; j++) begin
			cur_d[j]   = (cmd.wr_en && cmd.wr_slot == 3'(j)) ? data_byte : cur_q[j];
			slot_eq[j] = (((last_slot == 3'(j)) ? data_byte : cur_q[j]) == prev_q[j]);
		end
	end

	assign status.cen_en     = (century_index_q != 7'd0);
	assign status.cen_index  = century_index_q;
	assign status.snap_equal = (&slot_eq[NUM_SLOTS-2:0]) &&
		(slot_eq[NUM_SLOTS-1] || !status.cen_en);

	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_SLOTS; j++) begin
			if (cmd.wr_en && cmd.wr_slot == 3'(j)) cur_q[j] <= data_byte;
			if (cmd.copy_prev) prev_q[j] <= cur_d[j];
		end
	end

	// Conversion on the status B word; data_byte holds status B here.
	assign bin_mode = data_byte[BIN_MODE_BIT];
	assign hr_c = bin_mode ? cur_q[SLOT_HOUR]
		: ((8'(cur_q[SLOT_HOUR][3:0]) + 8'(cur_q[SLOT_HOUR][6:4]) * 8'd10)
			| {cur_q[SLOT_HOUR][PM_BIT], 7'd0});
	assign hr_24 = (!data_byte[H24_MODE_BIT] && hr_c[PM_BIT])
		? mod24(8'(hr_c[6:0]) + 8'd12) : hr_c;

	always_ff @(posedge clk) begin
		if (cmd.convert) begin
			sec_q <= bin_mode ? cur_q[SLOT_SECOND]  : bcd_to_bin(cur_q[SLOT_SECOND]);
			min_q <= bin_mode ? cur_q[SLOT_MINUTE]  : bcd_to_bin(cur_q[SLOT_MINUTE]);
			day_q <= bin_mode ? cur_q[SLOT_DAY]     : bcd_to_bin(cur_q[SLOT_DAY]);
			mon_q <= bin_mode ? cur_q[SLOT_MONTH]   : bcd_to_bin(cur_q[SLOT_MONTH]);
			yr_q  <= bin_mode ? cur_q[SLOT_YEAR]    : bcd_to_bin(cur_q[SLOT_YEAR]);
			cen_q <= bin_mode ? cur_q[SLOT_CENTURY] : bcd_to_bin(cur_q[SLOT_CENTURY]);
			hr_q  <= hr_24;
		end
	end

	// Year formation in the cycle after conversion.
	assign cen_year   = 15'(yr_q) + 15'(cen_q) * 15'd100;
	assign floor_year = 15'(base_cent_q) * 15'd100;
	assign sum_year   = 15'(yr_q) + floor_year;
	assign year_d = status.cen_en ? cen_year
		: ((sum_year < 15'(base_year_q)) ? sum_year + 15'd100 : sum_year);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit_req || cmd.emit_time;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_time) begin
			kind_q      <= KIND_TIME;
			reg_index_q <= '0;
			sec_o_q     <= sec_q;
			min_o_q     <= min_q;
			hr_o_q      <= hr_q;
			day_o_q     <= day_q;
			mon_o_q     <= mon_q;
			year_o_q    <= year_d;
		end else if (cmd.emit_req) begin
			kind_q      <= KIND_REQUEST;
			reg_index_q <= cmd.req_index;
			sec_o_q     <= '0;
			min_o_q     <= '0;
			hr_o_q      <= '0;
			day_o_q     <= '0;
			mon_o_q     <= '0;
			year_o_q    <= '0;
		end
	end

	assign done        = done_q;
	assign result_kind = kind_q;
	assign reg_index   = reg_index_q;
	assign out_second  = sec_o_q;
	assign out_minute  = min_o_q;
	assign out_hour    = hr_o_q;
	assign out_day     = day_o_q;
	assign out_month   = mon_o_q;
	assign out_year    = year_o_q;

endmodule
`default_nettype wire

/* rtl/core/cmos_rtc_consistent_reader.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cmos_rtc_consistent_reader
// Master that reads a CMOS real-time clock until two snapshots agree and
// returns the converted time with a full year.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     start, busy          req_type, data_byte
// result    done (one cycle)     result_kind, reg_index, out_second .. out_year
// config    cfg_we               cfg_index, cfg_data
//
// Each accepted word gives its result, if any, on the next cycle with
// done high for exactly that cycle.
// After the status B word, busy is high for one cycle while the year
// adder runs, and the time result follows it.
// A data word while idle is taken and gives no result.
// Reset is asynchronous and clears the sequencer, strobe and configuration.
// The receiver cannot stall; a result is lost if not taken in its cycle.
// ----------------------------------------------------------------------------
module cmos_rtc_consistent_reader (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        req_type,
	input  wire logic [7:0]  data_byte,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [13:0] cfg_data,
	output logic             done,
	output logic             result_kind,
	output logic [6:0]       reg_index,
	output logic [7:0]       out_second,
	output logic [7:0]       out_minute,
	output logic [7:0]       out_hour,
	output logic [7:0]       out_day,
	output logic [7:0]       out_month,
	output logic [14:0]      out_year
);
	import crtc_pkg::*;

	crtc_cmd_t    cmd;
	crtc_status_t status;

	crtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req_type  (req_type),
		.data_byte (data_byte),
		.status    (status),
		.busy      (busy),
		.cmd       (cmd)
	);

	crtc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_byte   (data_byte),
		.cmd         (cmd),
		.status      (status),
		.done        (done),
		.result_kind (result_kind),
		.reg_index   (reg_index),
		.out_second  (out_second),
		.out_minute  (out_minute),
		.out_hour    (out_hour),
		.out_day     (out_day),
		.out_month   (out_month),
		.out_year    (out_year)
	);

`ifndef SYNTHESIS
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_busy_then_time: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> (done && result_kind == KIND_TIME))
		else $error("finish cycle not followed by a time result");

	a_done_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without an accepted word");

	a_time_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_kind == KIND_TIME) |-> $past(busy))
		else $error("time result outside the finish sequence");
`endif

endmodule
`default_nettype wire

/* verif/cmos_rtc_consistent_reader_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmos_rtc_consistent_reader_test
// Drives the clock reader with start and data words while a small RTC
// responder inside the bench answers each register request. A predictor
// running beside the block works out every request and finished time.
// Each strobed result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module cmos_rtc_consistent_reader_test;
	import crtc_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 6;
	localparam int RANDOM_WORDS = 350;
	localparam int UPSET_WORDS  = 200;

	// CMOS registers that hold the six time slots, in slot order.
	localparam logic [5:0][6:0] SLOT_REGS =
		{REG_YEAR, REG_MONTH, REG_DAY, REG_HOUR, REG_MINUTE, REG_SECOND};

	typedef enum logic [1:0] {RD_IDLE, RD_STATUS_A, RD_SLOTS, RD_STATUS_B} read_phase_t;

	typedef struct packed {
		logic        kind;
		logic [6:0]  index;
		logic [7:0]  second;
		logic [7:0]  minute;
		logic [7:0]  hour;
		logic [7:0]  day;
		logic [7:0]  month;
		logic [14:0] year;
	} rtc_word_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        start     = 1'b0;
	logic        req_type  = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [13:0] cfg_data  = '0;
	logic        busy;
	logic        done;
	logic        result_kind;
	logic [6:0]  reg_index;
	logic [7:0]  out_second;
	logic [7:0]  out_minute;
	logic [7:0]  out_hour;
	logic [7:0]  out_day;
	logic [7:0]  out_month;
	logic [14:0] out_year;

	// Predicted state of the reader.
	read_phase_t     rd_phase     = RD_IDLE;
	int              rd_slot      = 0;
	bit              rd_have_prev = 1'b0;
	logic [6:0][7:0] cur_snap     = '0;
	logic [6:0][7:0] prev_snap    = '0;
	logic [6:0]      cfg_century  = '0;
	logic [13:0]     cfg_base     = BASE_YEAR_RESET;

	rtc_word_t pending_words[$];
	rtc_word_t seen_word;
	rtc_word_t want_word;
	int        faults      = 0;
	int        words_taken = 0;
	int        cycles      = 0;
	bit        gapless     = 1'b0;

	cmos_rtc_consistent_reader DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.data_byte   (data_byte),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.result_kind (result_kind),
		.reg_index   (reg_index),
		.out_second  (out_second),
		.out_minute  (out_minute),
		.out_hour    (out_hour),
		.out_day     (out_day),
		.out_month   (out_month),
		.out_year    (out_year)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int bcd_value(input int v);
		return (v & 'h0F) + ((v >> 4) & 'h0F) * 10;
	endfunction

	function automatic void expect_request(input logic [6:0] idx);
		rtc_word_t w;
		w = '0;
		w.kind = KIND_REQUEST;
		w.index = idx;
		pending_words.push_back(w);
	endfunction

	// Works out the result of one accepted word and advances the predicted state.
	function automatic void predict_clock_word(input logic kind, input logic [7:0] data);
		rtc_word_t w;
		bit same;
		int n, k;
		int sec, mnt, hr, dy, mon, yr, cen, full_year;
		if (kind == REQ_START) begin
			rd_have_prev = 1'b0;
			rd_phase = RD_STATUS_A;
			expect_request(REG_STATUS_A);
			return;
		end
		case (rd_phase)
			RD_STATUS_A: begin
				if (data[UIP_BIT]) begin
					expect_request(REG_STATUS_A);
				end else begin
					rd_phase = RD_SLOTS;
					rd_slot = 0;
					expect_request(SLOT_REGS[0]);
				end
			end
			RD_SLOTS: begin
				cur_snap[rd_slot] = data;
				if (rd_slot < 5) begin
					rd_slot++;
					expect_request(SLOT_REGS[rd_slot]);
				end else if (rd_slot == 5 && cfg_century != 0) begin
					rd_slot = 6;
					expect_request(cfg_century);
				end else begin
					same = rd_have_prev;
					n = (cfg_century != 0) ? 7 : 6;
					for (k = 0; k < n; k++)
						if (cur_snap[k] !== prev_snap[k])
							same = 1'b0;
					if (same) begin
						rd_phase = RD_STATUS_B;
						expect_request(REG_STATUS_B);
					end else begin
						prev_snap = cur_snap;
						rd_have_prev = 1'b1;
						rd_phase = RD_STATUS_A;
						expect_request(REG_STATUS_A);
					end
				end
			end
			RD_STATUS_B: begin
				sec = cur_snap[SLOT_SECOND];
				mnt = cur_snap[SLOT_MINUTE];
				hr  = cur_snap[SLOT_HOUR];
				dy  = cur_snap[SLOT_DAY];
				mon = cur_snap[SLOT_MONTH];
				yr  = cur_snap[SLOT_YEAR];
				cen = cur_snap[SLOT_CENTURY];
				if (!data[BIN_MODE_BIT]) begin
					sec = bcd_value(sec);
					mnt = bcd_value(mnt);
					// The PM flag rides above the two hour digits.
					hr  = ((hr & 'h0F) + ((hr & 'h70) >> 4) * 10) | (hr & 'h80);
					dy  = bcd_value(dy);
					mon = bcd_value(mon);
					yr  = bcd_value(yr);
					cen = bcd_value(cen);
				end
				if (!data[H24_MODE_BIT] && (hr & 'h80) != 0)
					hr = ((hr & 'h7F) + 12) % 24;
				if (cfg_century != 0) begin
					full_year = yr + cen * 100;
				end else begin
					full_year = yr + (int'(cfg_base) / 100) * 100;
					if (full_year < int'(cfg_base))
						full_year += 100;
				end
				w = '0;
				w.kind = KIND_TIME;
				w.second = sec[7:0];
				w.minute = mnt[7:0];
				w.hour = hr[7:0];
				w.day = dy[7:0];
				w.month = mon[7:0];
				w.year = full_year[14:0];
				pending_words.push_back(w);
				rd_phase = RD_IDLE;
				rd_have_prev = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// Results are taken at the edge that ends their strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			seen_word = {result_kind, reg_index, out_second, out_minute, out_hour,
				out_day, out_month, out_year};
			if (pending_words.size() == 0) begin
				if (faults < 10)
					$display("%0t: unexpected result kind=%0d index=%h", $realtime,
						result_kind, reg_index);
				faults++;
			end else begin
				want_word = pending_words.pop_front();
				if (seen_word.kind !== want_word.kind || seen_word.index !== want_word.index
						|| seen_word.second !== want_word.second
						|| seen_word.minute !== want_word.minute
						|| seen_word.hour !== want_word.hour
						|| seen_word.day !== want_word.day
						|| seen_word.month !== want_word.month
						|| seen_word.year !== want_word.year) begin
					if (faults < 10) begin
						$display("%0t: result mismatch", $realtime);
						$display("  expected kind=%0d index=%h time=%0d:%0d:%0d date=%0d/%0d/%0d",
							want_word.kind, want_word.index, want_word.hour,
							want_word.minute, want_word.second, want_word.day,
							want_word.month, want_word.year);
						$display("  actual   kind=%0d index=%h time=%0d:%0d:%0d date=%0d/%0d/%0d",
							seen_word.kind, seen_word.index, seen_word.hour,
							seen_word.minute, seen_word.second, seen_word.day,
							seen_word.month, seen_word.year);
					end
					faults++;
				end
			end
		end
	end

	// Sends one word and predicts its result once the block has taken it.
	task automatic send_word(input logic kind, input logic [7:0] data);
		int gap;
		gap = gapless ? 0 : $urandom_range(0, 12);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		data_byte <= data;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		if (!(kind == REQ_DATA && rd_phase == RD_IDLE))
			words_taken++;
		predict_clock_word(kind, data);
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		// A data word taken while idle leaves nothing to wait on.
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [13:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_CENTURY_INDEX)
			cfg_century = value[6:0];
		else
			cfg_base = value;
	endtask

	// A well-behaved clock: a number of busy status reads, then passes over the
	// snapshot until two agree. Slot 0 of the first pass may be disturbed.
	// snap is packed with the century in the top byte and the second at the bottom.
	task automatic clean_read(input logic [6:0][7:0] snap, input logic [7:0] status_b,
			input int uip_reads, input bit unstable);
		int p, k, passes, n;
		passes = unstable ? 3 : 2;
		n = (cfg_century != 0) ? 7 : 6;
		send_word(REQ_START, 8'h00);
		repeat (uip_reads) send_word(REQ_DATA, 8'hFF);
		for (p = 0; p < passes; p++) begin
			send_word(REQ_DATA, (p == 0) ? 8'h7F : 8'h00);
			for (k = 0; k < n; k++)
				send_word(REQ_DATA, snap[k] ^ ((unstable && p == 0 && k == 0) ? 8'h01 : 8'h00));
		end
		send_word(REQ_DATA, status_b);
	endtask

	// Answers the reader's requests from a random target time. upset_pct is the
	// chance that a slot read returns a changed byte, forcing another pass.
	// Upsets stop after a while so that every read runs to its end.
	task automatic read_clock(input int upset_pct);
		logic [6:0][7:0] target;
		logic [7:0] b;
		int k, guard;
		for (k = 0; k < 7; k++) begin
			if ($urandom_range(0, 2) == 0)
				target[k] = 8'($urandom);
			else
				target[k] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
		end
		if ($urandom_range(0, 1) == 1)
			target[SLOT_HOUR] = {1'b1, 3'($urandom_range(0, 1)), 4'($urandom_range(0, 9))};
		send_word(REQ_START, 8'($urandom));
		guard = 0;
		while (rd_phase != RD_IDLE && guard < 1000) begin
			guard++;
			case (rd_phase)
				RD_STATUS_A: b = ($urandom_range(0, 3) == 0) ? (8'h80 | 8'($urandom))
					: (8'h7F & 8'($urandom));
				RD_SLOTS: b = (guard < UPSET_WORDS && $urandom_range(0, 99) < upset_pct)
					? 8'($urandom) : target[rd_slot];
				default: b = 8'($urandom);
			endcase
			if ($urandom_range(0, 99) < 2)
				send_word(REQ_START, b);
			else
				send_word(REQ_DATA, b);
		end
		if ($urandom_range(0, 3) == 0)
			send_word(REQ_DATA, 8'($urandom));
	endtask

	task automatic test_idle_data;
		send_word(REQ_DATA, 8'hFF);
		send_word(REQ_DATA, 8'h00);
	endtask

	// Reset settings: no century register, base year 2016, so year 15 wraps
	// to 2115. Hour 12 PM in BCD becomes 0. A restart cuts the first try short.
	task automatic test_twelve_hour_restart;
		gapless = 1'b1;
		send_word(REQ_START, 8'hFF);
		send_word(REQ_DATA, 8'h00);
		send_word(REQ_DATA, 8'h45);
		gapless = 1'b0;
		clean_read({8'h00, 8'h15, 8'h12, 8'h31, 8'h92, 8'h59, 8'h00}, 8'h00, 2, 1'b0);
	endtask

	task automatic test_binary_unstable;
		clean_read({8'd0, 8'd99, 8'd1, 8'd1, 8'd23, 8'd0, 8'd59}, 8'hFF, 0, 1'b1);
	endtask

	task automatic test_wide_digits;
		gapless = 1'b1;
		clean_read({7{8'hFF}}, 8'h02, 1, 1'b0);
		clean_read({7{8'hFF}}, 8'h00, 0, 1'b0);
		gapless = 1'b0;
	endtask

	task automatic test_config_extremes;
		write_reg(CFG_CENTURY_INDEX, 14'd1);
		clean_read({8'h20, 8'h24, 8'h02, 8'h29, 8'h11, 8'h30, 8'h45}, 8'h00, 0, 1'b0);
		read_clock(10);
		write_reg(CFG_CENTURY_INDEX, 14'd127);
		clean_read({8'hFF, 8'hFF, 8'h12, 8'h31, 8'h23, 8'h59, 8'h59}, 8'h04, 0, 1'b1);
		read_clock(10);
		write_reg(CFG_CENTURY_INDEX, 14'd0);
		write_reg(CFG_BASE_YEAR, 14'd1900);
		read_clock(5);
		write_reg(CFG_BASE_YEAR, 14'd9999);
		clean_read({8'h00, 8'h98, 8'h06, 8'h15, 8'h08, 8'h00, 8'h00}, 8'h00, 0, 1'b0);
		read_clock(5);
		write_reg(CFG_CENTURY_INDEX, 14'h32);
		write_reg(CFG_BASE_YEAR, BASE_YEAR_RESET);
		read_clock(5);
	endtask

	task automatic test_random_reads;
		int goal;
		goal = words_taken + RANDOM_WORDS;
		while (words_taken < goal) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) == 0)
					write_reg(CFG_CENTURY_INDEX, ($urandom_range(0, 1) == 0) ? 14'd0
						: 14'($urandom_range(1, 127)));
				else
					write_reg(CFG_BASE_YEAR, 14'($urandom_range(1900, 9999)));
			end
			gapless = ($urandom_range(0, 3) == 0);
			read_clock($urandom_range(0, 25));
		end
		gapless = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_data();
		test_twelve_hour_restart();
		test_binary_unstable();
		test_wide_digits();
		test_config_extremes();
		test_random_reads();
		drain();
		if (faults == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
